/* src/ngpd_pkg.sv */
// Shared constants, types and helpers for the nearest-grid-point mass deposit block.
package ngpd_pkg;

    // Grid geometry
    localparam int MAX_SIZE   = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CELL_W     = $clog2(MAX_SIZE);
    localparam int DIM_W      = CELL_W + 1;
    localparam int GRID_DEPTH = MAX_SIZE * MAX_SIZE * MAX_SIZE;
    localparam int GRID_AW    = $clog2(GRID_DEPTH);
    localparam int YZ_W       = $clog2(MAX_SIZE * MAX_SIZE);
    localparam int YZ_PROD_W  = YZ_W + DIM_W;

    // Field widths
    localparam int POS_W      = 32;
    localparam int DIFF_W     = POS_W + 1;
    localparam int MASS_W     = 32;
    localparam int INV_W      = 32;
    localparam int SIZE_W     = 6;
    localparam int AXES_W     = 2;
    localparam int IDX_W      = 15;
    localparam int SUM_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Fixed-point product and rounding position
    localparam int PROD_W     = POS_W + INV_W;
    localparam int RND_SH     = 2 * FRAC_BITS;

    localparam logic [SUM_W-1:0] ACC_MAX = {SUM_W{1'b1}};

    // Reset values of the configuration registers
    localparam logic [AXES_W-1:0] AXES_RST = AXES_W'(3);
    localparam logic [INV_W-1:0]  INV_RST  = INV_W'(65536);
    localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(32);

    typedef enum logic {
        CMD_DEPOSIT = 1'b0,
        CMD_READ    = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_AXES = 3'd0,
        CFG_LEFT_X   = 3'd1,
        CFG_LEFT_Y   = 3'd2,
        CFG_LEFT_Z   = 3'd3,
        CFG_INV_CELL = 3'd4,
        CFG_SIZE_X   = 3'd5,
        CFG_SIZE_Y   = 3'd6,
        CFG_SIZE_Z   = 3'd7
    } t_cfg_reg;

    // Stage enables for one axis mapper
    typedef struct packed {
        logic load;
        logic mul;
        logic clamp;
    } t_axis_ctl;

    // Request from the sequencer to the grid memory
    typedef struct packed {
        logic               rd_en;
        logic [GRID_AW-1:0] rd_addr;
        logic               commit;
        logic               deposit;
        logic [MASS_W-1:0]  mass;
    } t_grid_req;

    // Response from the grid memory
    typedef struct packed {
        logic             busy;
        logic [SUM_W-1:0] sum;
        logic             saturated;
    } t_grid_rsp;

    // Map a programmed size onto 1..MAX_SIZE
    function automatic logic [DIM_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [DIM_W-1:0] r;
        if (s == '0) begin
            r = DIM_W'(1);
        end else if (s > SIZE_W'(MAX_SIZE)) begin
            r = DIM_W'(MAX_SIZE);
        end else begin
            r = DIM_W'(s);
        end
        return r;
    endfunction

endpackage

/* src/ngpd_if.sv */
// Handshake channel interfaces for items, results and configuration writes.
interface ngpd_in_if;
    logic                              valid;
    logic                              ready;
    logic                              command;
    logic signed [ngpd_pkg::POS_W-1:0] pos_x;
    logic signed [ngpd_pkg::POS_W-1:0] pos_y;
    logic signed [ngpd_pkg::POS_W-1:0] pos_z;
    logic [ngpd_pkg::MASS_W-1:0]       mass;
    logic [ngpd_pkg::IDX_W-1:0]        read_cell;

    modport source (output valid, command, pos_x, pos_y, pos_z, mass, read_cell,
                    input ready);
    modport sink   (input valid, command, pos_x, pos_y, pos_z, mass, read_cell,
                    output ready);
endinterface

interface ngpd_out_if;
    logic                       valid;
    logic                       ready;
    logic [ngpd_pkg::IDX_W-1:0] cell_index;
    logic [ngpd_pkg::SUM_W-1:0] cell_sum;
    logic                       saturated;

    modport source (output valid, cell_index, cell_sum, saturated, input ready);
    modport sink   (input valid, cell_index, cell_sum, saturated, output ready);
endinterface

interface ngpd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ngpd_pkg::CFG_IDX_W-1:0]  index;
    logic [ngpd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/ngp_mass_deposit.sv */
// Top level of the nearest-grid-point mass deposit: sequencer, configuration and result register.
//
// Scatter-adds Q16.16 particle masses into a grid of up to 32x32x32 48-bit accumulators
// held in one synchronous memory; each deposit returns the touched linear cell index and its
// new saturated sum, and a read command returns one stored cell. After reset a clearing pass
// writes zero to all 32768 entries, one per cycle, and no item is taken until it finishes
// (configuration writes are taken at any time). Items are handled one at a time: a deposit
// passes through difference on the transfer, 32x32 multiply, round and clamp, two index
// steps with the memory read issued on the second, then add and write back, where its result
// is loaded; a read passes through the memory read on the transfer, then result. The result
// sits in an output register, so the next item is taken while it waits; the sequencer holds
// in its last step only while that register is full and not being drained.
module ngp_mass_deposit (
    input  logic i_clk,
    input  logic i_rst_n,
    ngpd_in_if.sink    i_in,
    ngpd_out_if.source o_out,
    ngpd_cfg_if.sink   i_cfg
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_CELL  = 7'b0001000,
        S_IDX1  = 7'b0010000,
        S_IDX2  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [ngpd_pkg::AXES_W-1:0]       r_num_axes;
    logic signed [ngpd_pkg::POS_W-1:0] r_left_x, r_left_y, r_left_z;
    logic [ngpd_pkg::INV_W-1:0]        r_inv;
    logic [ngpd_pkg::SIZE_W-1:0]       r_size_x, r_size_y, r_size_z;

    // Item registers
    logic                         r_cmd;
    logic [ngpd_pkg::MASS_W-1:0]  r_mass;
    logic [ngpd_pkg::YZ_W-1:0]    r_yz;
    logic [ngpd_pkg::GRID_AW-1:0] r_idx;

    // Result register
    logic                       r_out_valid;
    logic [ngpd_pkg::IDX_W-1:0] r_out_index;
    logic [ngpd_pkg::SUM_W-1:0] r_out_sum;
    logic                       r_out_sat;

    logic                          in_xfer;
    logic                          slot_free;
    logic                          commit;
    logic [ngpd_pkg::DIM_W-1:0]    dim_x, dim_y, dim_z;
    logic [ngpd_pkg::CELL_W-1:0]   cell_x, cell_y, cell_z;
    logic [ngpd_pkg::CELL_W-1:0]   cy_eff, cz_eff;
    logic [ngpd_pkg::YZ_W-1:0]     n_yz;
    logic [ngpd_pkg::GRID_AW-1:0]  idx;
    ngpd_pkg::t_axis_ctl           axis_ctl;
    ngpd_pkg::t_grid_req           grid_req;
    ngpd_pkg::t_grid_rsp           grid_rsp;

    assign in_xfer   = i_in.valid && i_in.ready;
    assign slot_free = !r_out_valid || o_out.ready;
    assign commit    = (r_state == S_DONE) && slot_free;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_axes <= ngpd_pkg::AXES_RST;
            r_left_x   <= '0;
            r_left_y   <= '0;
            r_left_z   <= '0;
            r_inv      <= ngpd_pkg::INV_RST;
            r_size_x   <= ngpd_pkg::SIZE_RST;
            r_size_y   <= ngpd_pkg::SIZE_RST;
            r_size_z   <= ngpd_pkg::SIZE_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                ngpd_pkg::CFG_NUM_AXES: r_num_axes <= i_cfg.data[ngpd_pkg::AXES_W-1:0];
                ngpd_pkg::CFG_LEFT_X:   r_left_x   <= i_cfg.data;
                ngpd_pkg::CFG_LEFT_Y:   r_left_y   <= i_cfg.data;
                ngpd_pkg::CFG_LEFT_Z:   r_left_z   <= i_cfg.data;
                ngpd_pkg::CFG_INV_CELL: r_inv      <= i_cfg.data;
                ngpd_pkg::CFG_SIZE_X:   r_size_x   <= i_cfg.data[ngpd_pkg::SIZE_W-1:0];
                ngpd_pkg::CFG_SIZE_Y:   r_size_y   <= i_cfg.data[ngpd_pkg::SIZE_W-1:0];
                ngpd_pkg::CFG_SIZE_Z:   r_size_z   <= i_cfg.data[ngpd_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign dim_x = ngpd_pkg::eff_size(r_size_x);
    assign dim_y = ngpd_pkg::eff_size(r_size_y);
    assign dim_z = ngpd_pkg::eff_size(r_size_z);

    // Axis mappers
    assign axis_ctl.load  = in_xfer;
    assign axis_ctl.mul   = (r_state == S_MUL);
    assign axis_ctl.clamp = (r_state == S_CELL);

    ngpd_axis u_axis_x (
        .i_clk  (i_clk),
        .i_ctl  (axis_ctl),
        .i_pos  (i_in.pos_x),
        .i_left (r_left_x),
        .i_inv  (r_inv),
        .i_dim  (dim_x),
        .o_cell (cell_x)
    );

    ngpd_axis u_axis_y (
        .i_clk  (i_clk),
        .i_ctl  (axis_ctl),
        .i_pos  (i_in.pos_y),
        .i_left (r_left_y),
        .i_inv  (r_inv),
        .i_dim  (dim_y),
        .o_cell (cell_y)
    );

    ngpd_axis u_axis_z (
        .i_clk  (i_clk),
        .i_ctl  (axis_ctl),
        .i_pos  (i_in.pos_z),
        .i_left (r_left_z),
        .i_inv  (r_inv),
        .i_dim  (dim_z),
        .o_cell (cell_z)
    );

    // Drop unused axes to cell 0
    assign cy_eff = (r_num_axes >= ngpd_pkg::AXES_W'(2)) ? cell_y : '0;
    assign cz_eff = (r_num_axes == ngpd_pkg::AXES_W'(3)) ? cell_z : '0;

    // Linear index in two registered multiply steps
    assign n_yz = ngpd_pkg::YZ_W'(ngpd_pkg::YZ_PROD_W'(cy_eff)
                + ngpd_pkg::YZ_PROD_W'(cz_eff) * ngpd_pkg::YZ_PROD_W'(dim_y));
    assign idx  = ngpd_pkg::GRID_AW'(ngpd_pkg::YZ_PROD_W'(cell_x)
                + ngpd_pkg::YZ_PROD_W'(r_yz) * ngpd_pkg::YZ_PROD_W'(dim_x));

    // Capture item fields and index
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd  <= i_in.command;
            r_mass <= i_in.mass;
            r_idx  <= ngpd_pkg::GRID_AW'(i_in.read_cell);
        end else if (r_state == S_IDX2) begin
            r_idx <= idx;
        end
        if (r_state == S_IDX1) begin
            r_yz <= n_yz;
        end
    end

    // Grid memory access
    always_comb begin
        grid_req.rd_en   = (in_xfer && (i_in.command == ngpd_pkg::CMD_READ))
                        || (r_state == S_IDX2);
        grid_req.rd_addr = (r_state == S_IDX2) ? idx : ngpd_pkg::GRID_AW'(i_in.read_cell);
        grid_req.commit  = commit;
        grid_req.deposit = (r_cmd == ngpd_pkg::CMD_DEPOSIT);
        grid_req.mass    = r_mass;
    end

    ngpd_grid u_grid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (grid_req),
        .o_rsp   (grid_rsp)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (!grid_rsp.busy) begin
                n_state = S_IDLE;
            end
            S_IDLE: if (in_xfer) begin
                n_state = (i_in.command == ngpd_pkg::CMD_READ) ? S_DONE : S_MUL;
            end
            S_MUL:   n_state = S_CELL;
            S_CELL:  n_state = S_IDX1;
            S_IDX1:  n_state = S_IDX2;
            S_IDX2:  n_state = S_DONE;
            S_DONE: if (slot_free) begin
                n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Result register: load on commit, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_index <= ngpd_pkg::IDX_W'(r_idx);
            r_out_sum   <= grid_rsp.sum;
            r_out_sat   <= grid_rsp.saturated;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.cell_index = r_out_index;
    assign o_out.cell_sum   = r_out_sum;
    assign o_out.saturated  = r_out_sat;

`ifndef SYNTHESIS
    // No item is taken while the grid is being cleared
    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        grid_rsp.busy |-> !i_in.ready)
        else $error("item accepted during grid clear");

    // One item at a time: no transfer in the cycle after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !i_in.ready)
        else $error("input ready right after a transfer");

    // A commit always leaves a valid result behind
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> o_out.valid)
        else $error("committed result not presented");

    // A saturated deposit shows the full-scale sum
    a_sat_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.saturated) |-> (o_out.cell_sum == ngpd_pkg::ACC_MAX))
        else $error("saturated flag without full-scale sum");
`endif

endmodule

/* src/ngpd_axis.sv */
// Per-axis position to cell mapper: subtract, multiply by the inverse cell size, round, clamp.
module ngpd_axis (
    input  logic                              i_clk,
    input  ngpd_pkg::t_axis_ctl               i_ctl,
    input  logic signed [ngpd_pkg::POS_W-1:0] i_pos,
    input  logic signed [ngpd_pkg::POS_W-1:0] i_left,
    input  logic [ngpd_pkg::INV_W-1:0]        i_inv,
    input  logic [ngpd_pkg::DIM_W-1:0]        i_dim,
    output logic [ngpd_pkg::CELL_W-1:0]       o_cell
);

    logic [ngpd_pkg::POS_W-1:0]  r_diff;
    logic                        r_nonpos;
    logic [ngpd_pkg::PROD_W-1:0] r_prod;
    logic [ngpd_pkg::CELL_W-1:0] r_cell;

    logic signed [ngpd_pkg::DIFF_W-1:0] diff;
    logic [ngpd_pkg::PROD_W:0]          prod_sh;
    logic                               rnd;
    logic [ngpd_pkg::PROD_W:0]          q;
    logic [ngpd_pkg::CELL_W-1:0]        n_cell;

    // Exact difference; a non-positive one maps to the first cell
    assign diff = ngpd_pkg::DIFF_W'(i_pos) - ngpd_pkg::DIFF_W'(i_left);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_diff   <= diff[ngpd_pkg::POS_W-1:0];
            r_nonpos <= diff[ngpd_pkg::DIFF_W-1] || (diff == '0);
        end
        if (i_ctl.mul) begin
            r_prod <= ngpd_pkg::PROD_W'(r_diff) * ngpd_pkg::PROD_W'(i_inv);
        end
        if (i_ctl.clamp) begin
            r_cell <= n_cell;
        end
    end

    // Round to nearest: integer part plus the first dropped fraction bit
    assign prod_sh = {r_prod, 1'b0};
    assign rnd     = prod_sh[ngpd_pkg::RND_SH];
    assign q       = (ngpd_pkg::PROD_W + 1)'(r_prod >> ngpd_pkg::RND_SH)
                   + (ngpd_pkg::PROD_W + 1)'(rnd);

    // Clamp to 1..dim and step down to a zero-based cell
    always_comb begin
        priority if (r_nonpos || (q == '0)) begin
            n_cell = '0;
        end else if (q > (ngpd_pkg::PROD_W + 1)'(i_dim)) begin
            n_cell = ngpd_pkg::CELL_W'(i_dim - ngpd_pkg::DIM_W'(1));
        end else begin
            n_cell = ngpd_pkg::CELL_W'(q - (ngpd_pkg::PROD_W + 1)'(1));
        end
    end

    assign o_cell = r_cell;

endmodule

/* src/ngpd_grid.sv */
// Grid accumulator memory with clearing sweep after reset and saturating read-modify-write.
module ngpd_grid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ngpd_pkg::t_grid_req i_req,
    output ngpd_pkg::t_grid_rsp o_rsp
);

    logic [ngpd_pkg::SUM_W-1:0]   r_mem [ngpd_pkg::GRID_DEPTH];
    logic [ngpd_pkg::SUM_W-1:0]   r_rd_data;
    logic [ngpd_pkg::GRID_AW-1:0] r_addr;
    logic                         r_clr_busy;
    logic [ngpd_pkg::GRID_AW-1:0] r_clr_addr;

    logic [ngpd_pkg::SUM_W:0]   add_full;
    logic [ngpd_pkg::SUM_W-1:0] add_sat;
    logic [ngpd_pkg::SUM_W-1:0] sum;

    // Sweep every entry to zero once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + ngpd_pkg::GRID_AW'(1);
            if (r_clr_addr == ngpd_pkg::GRID_AW'(ngpd_pkg::GRID_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Saturating add of the mass to the fetched sum
    assign add_full = (ngpd_pkg::SUM_W + 1)'(r_rd_data) + (ngpd_pkg::SUM_W + 1)'(i_req.mass);
    assign add_sat  = add_full[ngpd_pkg::SUM_W] ? ngpd_pkg::ACC_MAX
                                                : add_full[ngpd_pkg::SUM_W-1:0];
    assign sum      = i_req.deposit ? add_sat : r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.commit && i_req.deposit) begin
            r_mem[r_addr] <= add_sat;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
            r_addr    <= i_req.rd_addr;
        end
    end

    assign o_rsp.busy      = r_clr_busy;
    assign o_rsp.sum       = sum;
    assign o_rsp.saturated = i_req.deposit && (add_sat == ngpd_pkg::ACC_MAX);

endmodule
